### src/nsc_pkg.sv
// Shared types, character codes and per-character helper functions of the NMEA sentence checker.
// No dependencies; imported by every module of the block.
package nsc_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NODOLLAR = 3'd2,
        ST_NOSTAR   = 3'd3,
        ST_NOCSUM   = 3'd4,
        ST_BADCSUM  = 3'd5,
        ST_OVERFLOW = 3'd6
    } line_status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_VTG   = 2'd2,
        KIND_RMC   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_WS   = 2'd0,
        PH_DIG  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    // Comma fields holding fix quality and satellite count in a GGA sentence.
    localparam logic [3:0] FIELD_QUALITY = 4'd6;
    localparam logic [3:0] FIELD_SATS    = 4'd7;
    localparam logic [3:0] COMMA_SAT     = 4'd8;

    localparam int PREFIX_LEN = 6;
    localparam int MIN_LEN    = 4;

    typedef logic [0:7][7:0] tag_t;
    localparam tag_t TAG_GGA = {"$GPGGA", 16'h0};
    localparam tag_t TAG_VTG = {"$GPVTG", 16'h0};
    localparam tag_t TAG_RMC = {"$GPRMC", 16'h0};

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        phase_t     ph;
        logic [8:0] acc;    // saturates at 256
        logic       neg;
        logic       any;
    } parse_t;

    localparam parse_t PARSE_INIT = '{ph: PH_WS, acc: 9'd0, neg: 1'b0, any: 1'b0};

    // Summary of one finished line, handed from front to back.
    typedef struct packed {
        logic       ovf;
        logic       short_line;
        logic [7:0] b0;
        logic [7:0] w1;     // last character
        logic [7:0] w2;     // second to last
        logic [7:0] w3;     // third to last
        logic [7:0] csum;
        kind_t      kind;
        logic       q_any;
        logic [7:0] q_val;
        logic       s_any;
        logic [7:0] s_val;
    } line_rec_t;

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Returns {valid, value}.
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h61:8'h66]})
            r = {1'b1, 4'(c - 8'h57)};
        else if (c inside {[8'h41:8'h46]})
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // One character of a decimal field: skip spaces, optional sign, digits.
    function automatic parse_t parse_step(parse_t p, logic [7:0] c);
        parse_t     r;
        logic [12:0] prod;
        r = p;
        prod = 13'(p.acc) * 13'd10 + 13'(c - 8'h30);
        case (p.ph)
            PH_WS:
            begin
                if (is_space(c))
                    r.ph = PH_WS;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    r.neg = (c == CH_MINUS);
                    r.ph  = PH_DIG;
                end
                else if (is_digit(c))
                begin
                    r.acc = 9'(c - 8'h30);
                    r.any = 1'b1;
                    r.ph  = PH_DIG;
                end
                else
                    r.ph = PH_DONE;
            end
            PH_DIG:
            begin
                if (is_digit(c))
                begin
                    r.acc = (prod > 13'd255) ? 9'd256 : prod[8:0];
                    r.any = 1'b1;
                end
                else
                    r.ph = PH_DONE;
            end
            default:
                r.ph = PH_DONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] parse_value(parse_t p);
        if (p.neg)
            return 8'd0;
        return p.acc[8] ? 8'd255 : p.acc[7:0];
    endfunction

endpackage

### src/nsc_front.sv
// Front end: takes one character per cycle while accept is high and keeps a running summary of the line.
// Depends on nsc_pkg; pushes one line_rec_t into the queue per line feed or overflow.
module nsc_front #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               push,
    output nsc_pkg::line_rec_t rec
);
    import nsc_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);

    // Raw count includes trailing carriage returns not yet known to be part of the line.
    logic [LEN_W-1:0] raw_len_reg, raw_len_next;
    logic [LEN_W-1:0] com_len_reg, com_len_next;
    logic [7:0]       b0_reg, b0_next;
    logic [7:0]       w1_reg, w1_next;
    logic [7:0]       w2_reg, w2_next;
    logic [7:0]       w3_reg, w3_next;
    logic [7:0]       x_reg, x_next;
    logic [2:0]       pfx_reg, pfx_next;      // gga, vtg, rmc still matching
    logic [3:0]       commas_reg, commas_next;
    parse_t           prs_reg [2];
    parse_t           prs_next [2];

    logic [LEN_W-1:0] run_len;
    logic             has_run;
    logic             is_lf;
    logic             is_cr;
    logic             ovf;
    logic [7:0]       a1, a2;
    parse_t           p_run;
    logic [2:0]       pos;

    always_comb
    begin
        run_len = raw_len_reg - com_len_reg;
        has_run = (run_len != '0);
        is_lf   = (rx_byte == CH_LF);
        is_cr   = (rx_byte == CH_CR);
        ovf     = !is_lf && (raw_len_reg == LEN_W'(LINE_CAPACITY - 2));
        pos     = raw_len_reg[2:0];

        raw_len_next = raw_len_reg;
        com_len_next = com_len_reg;
        b0_next      = b0_reg;
        w1_next      = w1_reg;
        w2_next      = w2_reg;
        w3_next      = w3_reg;
        x_next       = x_reg;
        pfx_next     = pfx_reg;
        commas_next  = commas_reg;
        prs_next     = prs_reg;
        p_run        = PARSE_INIT;

        // Window after committing the pending carriage returns.
        if (!has_run)
        begin
            a1 = w1_reg;
            a2 = w2_reg;
        end
        else if (run_len == LEN_W'(1))
        begin
            a1 = CH_CR;
            a2 = w1_reg;
        end
        else
        begin
            a1 = CH_CR;
            a2 = CH_CR;
        end

        if (accept)
        begin
            if (is_lf || ovf)
            begin
                raw_len_next = '0;
                com_len_next = '0;
                x_next       = 8'd0;
                pfx_next     = 3'b111;
                commas_next  = 4'd0;
                prs_next[0]  = PARSE_INIT;
                prs_next[1]  = PARSE_INIT;
            end
            else if (is_cr)
                raw_len_next = raw_len_reg + LEN_W'(1);
            else
            begin
                // Commit the pending carriage returns, then this character.
                raw_len_next = raw_len_reg + LEN_W'(1);
                com_len_next = raw_len_reg + LEN_W'(1);
                if (com_len_reg == '0)
                    b0_next = has_run ? CH_CR : rx_byte;
                w1_next = rx_byte;
                w2_next = a1;
                w3_next = a2;
                x_next  = x_reg ^ (run_len[0] ? CH_CR : 8'd0) ^ rx_byte;

                if (has_run && com_len_reg < LEN_W'(PREFIX_LEN))
                    pfx_next = 3'b000;
                if (raw_len_reg < LEN_W'(PREFIX_LEN))
                begin
                    if (rx_byte != TAG_GGA[pos])
                        pfx_next[2] = 1'b0;
                    if (rx_byte != TAG_VTG[pos])
                        pfx_next[1] = 1'b0;
                    if (rx_byte != TAG_RMC[pos])
                        pfx_next[0] = 1'b0;
                end

                for (int i = 0; i < 2; i++)
                begin
                    if (commas_reg == FIELD_QUALITY + 4'(i))
                    begin
                        p_run       = has_run ? parse_step(prs_reg[i], CH_CR) : prs_reg[i];
                        prs_next[i] = parse_step(p_run, rx_byte);
                    end
                end

                if (rx_byte == CH_COMMA && commas_reg != COMMA_SAT)
                    commas_next = commas_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        push           = accept && (is_lf || ovf);
        rec.ovf        = !is_lf;
        rec.short_line = (com_len_reg < LEN_W'(MIN_LEN));
        rec.b0         = b0_reg;
        rec.w1         = w1_reg;
        rec.w2         = w2_reg;
        rec.w3         = w3_reg;
        rec.csum       = x_reg ^ b0_reg ^ w1_reg ^ w2_reg ^ w3_reg;
        rec.kind       = KIND_OTHER;
        if (com_len_reg >= LEN_W'(PREFIX_LEN))
        begin
            if (pfx_reg[2])
                rec.kind = KIND_GGA;
            else if (pfx_reg[1])
                rec.kind = KIND_VTG;
            else if (pfx_reg[0])
                rec.kind = KIND_RMC;
        end
        rec.q_any = prs_reg[0].any;
        rec.q_val = parse_value(prs_reg[0]);
        rec.s_any = prs_reg[1].any;
        rec.s_val = parse_value(prs_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_len_reg <= '0;
            com_len_reg <= '0;
            x_reg       <= 8'd0;
            pfx_reg     <= 3'b111;
            commas_reg  <= 4'd0;
            prs_reg[0]  <= PARSE_INIT;
            prs_reg[1]  <= PARSE_INIT;
        end
        else
        begin
            raw_len_reg <= raw_len_next;
            com_len_reg <= com_len_next;
            x_reg       <= x_next;
            pfx_reg     <= pfx_next;
            commas_reg  <= commas_next;
            prs_reg     <= prs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        w3_reg <= w3_next;
    end

    a_commit_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
        com_len_reg <= raw_len_reg)
        else $error("committed length passed raw length");

endmodule

### src/nsc_queue.sv
// Two-entry queue of line summaries between front and back.
// Depends on nsc_pkg for line_rec_t and QUEUE_DEPTH.
module nsc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nsc_pkg::line_rec_t push_rec,
    input  logic               pop,
    output nsc_pkg::line_rec_t pop_rec,
    output logic               full,
    output logic               empty
);
    import nsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_rec_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == CNT_W'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        pop_rec     = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

### src/nsc_back.sv
// Back end: finishes the check of a line summary, updates the held GGA values and
// drives the result register. Depends on nsc_pkg.
module nsc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  nsc_pkg::line_rec_t rec,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_data
);
    import nsc_pkg::*;

    logic         valid_reg, valid_next;
    line_status_t status_reg, status_next;
    kind_t        kind_reg, kind_next;
    logic [7:0]   csum_reg, csum_next;
    logic [7:0]   quality_reg, quality_next;
    logic [7:0]   sats_reg, sats_next;

    logic [4:0]   h0, h1;
    logic [7:0]   v;
    logic         v_ok;

    always_comb
    begin
        pop = !empty && (!valid_reg || out_ready);

        h0   = hex_val(rec.w2);
        h1   = hex_val(rec.w1);
        v    = 8'd0;
        v_ok = 1'b1;
        if (h0[4])
            v = h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
        else if ((is_space(rec.w2) || rec.w2 == CH_PLUS) && h1[4])
            v = {4'd0, h1[3:0]};
        else if (rec.w2 == CH_MINUS && h1[4])
            v = 8'(-{4'd0, h1[3:0]});     // matches only a zero digit
        else
            v_ok = 1'b0;

        status_next  = ST_OK;
        kind_next    = KIND_OTHER;
        csum_next    = 8'd0;
        quality_next = quality_reg;
        sats_next    = sats_reg;

        if (rec.ovf)
            status_next = ST_OVERFLOW;
        else if (rec.short_line)
            status_next = ST_SHORT;
        else if (rec.b0 != CH_DOLLAR)
            status_next = ST_NODOLLAR;
        else if (rec.w3 != CH_STAR)
            status_next = ST_NOSTAR;
        else
        begin
            csum_next = rec.csum;
            if (!v_ok)
                status_next = ST_NOCSUM;
            else if (v != rec.csum || (rec.w2 == CH_MINUS && h1[3:0] != 4'd0))
                status_next = ST_BADCSUM;
            else
            begin
                kind_next = rec.kind;
                if (rec.kind == KIND_GGA)
                begin
                    if (rec.q_any)
                        quality_next = rec.q_val;
                    if (rec.s_any)
                        sats_next = rec.s_val;
                end
            end
        end

        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;

        out_valid = valid_reg;
        out_data  = {3'd0, sats_reg, quality_reg, csum_reg, kind_reg, status_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            quality_reg <= 8'd0;
            sats_reg    <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                quality_reg <= quality_next;
                sats_reg    <= sats_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            csum_reg   <= csum_next;
        end
    end

    a_kind_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != KIND_OTHER) |-> (status_reg == ST_OK))
        else $error("sentence kind reported on a failed line");

endmodule

### src/nmea_sentence_checker_top.sv
// NMEA 0183 sentence checker: receives a character stream and reports one result per line.
// Top level; instantiates nsc_front, nsc_queue and nsc_back, depends on nsc_pkg.
//
// Usage:
//   s_axis carries one received character per transfer (tdata[7:0]). A line feed ends a
//   line; one result then appears on m_axis. A line that reaches LINE_CAPACITY-1
//   characters without a line feed is dropped and gives an overflow result.
//   Other characters give no result.
//   The queue entry of a line is written at the edge that accepts its line feed; the back
//   result register takes it when the back end pops the entry, and the result is then valid.
//   One character is taken per cycle while s_axis_tready is high. The front folds each
//   character into a running summary (length, first and last three characters, XOR,
//   prefix match, GGA field parsers), so no line is stored or rescanned.
//   A two-entry queue lies between front and back. When m_axis stalls, results wait in
//   the result register and the queue; s_axis_tready drops only while the queue is full.
//   Reset: the line under collection is discarded and the held fix quality and
//   satellite count go to zero. The block is ready once reset is released.
module nmea_sentence_checker_top #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [2:0] line_status, [4:3] sentence_kind,
                                        // [12:5] computed_checksum, [20:13] fix_quality,
                                        // [28:21] satellite_count, [31:29] zero
);
    import nsc_pkg::*;

    logic      accept;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    line_rec_t push_rec;
    line_rec_t pop_rec;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    nsc_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_axis_tdata),
        .push    (push),
        .rec     (push_rec)
    );

    nsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    nsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .rec       (pop_rec),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### sim/tb_nmea_sentence_checker_top.sv
// Self-checking testbench for nmea_sentence_checker_top: streams sentence characters,
// predicts each line result and compares it with the result stream.
// Depends on nsc_pkg (status and kind codes, character constants) and the top level.
`timescale 1ns / 1ps

module tb_nmea_sentence_checker_top;

    import nsc_pkg::*;

    localparam int LINE_CAP     = 256;
    localparam int RANDOM_BYTES = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // Placeholders in the directed texts for bytes that a string cannot hold.
    localparam logic [7:0] MARK_ZERO = 8'h60;   // '`' stands for 0x00
    localparam logic [7:0] MARK_FF   = 8'h7E;   // '~' stands for 0xFF

    typedef struct packed {
        line_status_t status;
        kind_t        kind;
        logic [7:0]   csum;
        logic [7:0]   quality;
        logic [7:0]   sats;
    } report_t;

    typedef struct {
        string   text;
        int      rep;
        bit      typed;
        report_t want;
    } row_t;

    localparam report_t NO_REPORT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Sentence predictor state
    logic [7:0]  line_buf [0:LINE_CAP-1];
    int unsigned line_fill = 0;
    logic [7:0]  held_fix = 8'd0;
    logic [7:0]  held_sats = 8'd0;

    report_t     pending_reports [$];
    row_t        rows [$];
    logic [7:0]  line_bytes [$];
    int          errors = 0;
    int          cycles = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          stall_left = 0;
    report_t     head;

    nmea_sentence_checker_top #(
        .LINE_CAPACITY(LINE_CAP)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 10)
            return "0" + n;
        return (lower ? "a" : "A") + n - 10;
    endfunction

    function automatic bit head_is(int unsigned len, string tag);
        if (len < 6)
            return 1'b0;
        for (int i = 0; i < 6; i++)
            if (line_buf[i] != tag[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Decimal value of comma field k, or -1 when the field holds no digit.
    function automatic int field_value(int unsigned len, int unsigned k);
        int unsigned i;
        int unsigned commas;
        int          acc;
        bit          neg;
        bit          any;
        i = 0;
        commas = 0;
        acc = 0;
        neg = 1'b0;
        any = 1'b0;
        while (commas < k)
        begin
            if (i >= len)
                return -1;
            if (line_buf[i] == CH_COMMA)
                commas++;
            i++;
        end
        while (i < len && is_blank(line_buf[i]))
            i++;
        if (i < len && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS))
        begin
            neg = (line_buf[i] == CH_MINUS);
            i++;
        end
        while (i < len && line_buf[i] >= "0" && line_buf[i] <= "9")
        begin
            acc = acc * 10 + (line_buf[i] - "0");
            if (acc > 255)
                acc = 256;
            any = 1'b1;
            i++;
        end
        if (!any)
            return -1;
        if (neg)
            return 0;
        return (acc > 255) ? 255 : acc;
    endfunction

    function automatic report_t judge_line(int unsigned len);
        report_t    r;
        logic [7:0] x;
        logic [7:0] c0;
        int         d0;
        int         d1;
        int         v;
        int         f;
        bit         digits_ok;
        r = NO_REPORT;
        while (len >= 4 && line_buf[len-1] == CH_CR)
            len--;
        if (len < 4)
            r.status = ST_SHORT;
        else if (line_buf[0] != CH_DOLLAR)
            r.status = ST_NODOLLAR;
        else if (line_buf[len-3] != CH_STAR)
            r.status = ST_NOSTAR;
        else
        begin
            x = 8'd0;
            for (int unsigned i = 1; i < len - 3; i++)
                x ^= line_buf[i];
            r.csum = x;
            c0 = line_buf[len-2];
            d0 = nibble_of(c0);
            d1 = nibble_of(line_buf[len-1]);
            digits_ok = 1'b1;
            v = 0;
            if (d0 >= 0)
                v = (d1 >= 0) ? d0 * 16 + d1 : d0;
            else if ((is_blank(c0) || c0 == CH_PLUS) && d1 >= 0)
                v = d1;
            else if (c0 == CH_MINUS && d1 >= 0)
                v = -d1;
            else
                digits_ok = 1'b0;
            if (!digits_ok)
                r.status = ST_NOCSUM;
            else if (v != int'(x))
                r.status = ST_BADCSUM;
            else if (head_is(len, "$GPGGA"))
            begin
                r.kind = KIND_GGA;
                f = field_value(len, FIELD_QUALITY);
                if (f >= 0)
                    held_fix = f[7:0];
                f = field_value(len, FIELD_SATS);
                if (f >= 0)
                    held_sats = f[7:0];
            end
            else if (head_is(len, "$GPVTG"))
                r.kind = KIND_VTG;
            else if (head_is(len, "$GPRMC"))
                r.kind = KIND_RMC;
        end
        r.quality = held_fix;
        r.sats = held_sats;
        return r;
    endfunction

    // Advance the predictor by one character; returns 1 when a result is due.
    function automatic bit model_char(logic [7:0] c, output report_t r);
        int unsigned len;
        r = NO_REPORT;
        if (c == CH_LF)
        begin
            len = (line_fill > LINE_CAP - 1) ? LINE_CAP - 1 : line_fill;
            line_fill = 0;
            r = judge_line(len);
            return 1'b1;
        end
        if (line_fill >= LINE_CAP - 1)
            line_fill = 0;
        line_buf[line_fill] = c;
        line_fill++;
        if (line_fill >= LINE_CAP - 1)
        begin
            line_fill = 0;
            r.status = ST_OVERFLOW;
            r.quality = held_fix;
            r.sats = held_sats;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = $urandom_range(0, 254);
        if (b >= CH_LF)
            b++;
        return b;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic void add_row(string text, int rep, bit typed, report_t want);
        row_t r;
        r.text = text;
        r.rep = rep;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    // Expand a directed text; a "*hh" tail gets the correct checksum.
    function automatic void build_row(string text, int rep);
        logic [7:0] c;
        logic [7:0] x;
        line_bytes.delete();
        for (int r = 0; r < rep; r++)
            for (int i = 0; i < text.len(); i++)
            begin
                c = text[i];
                if (c == MARK_ZERO)
                    c = 8'h00;
                else if (c == MARK_FF)
                    c = 8'hFF;
                line_bytes.push_back(c);
            end
        for (int k = 0; k + 2 < line_bytes.size(); k++)
            if (line_bytes[k] == CH_STAR && line_bytes[k+1] == "h" && line_bytes[k+2] == "h")
            begin
                x = 8'd0;
                for (int i = 1; i < k; i++)
                    x ^= line_bytes[i];
                line_bytes[k+1] = hex_char(x[7:4], 1'b0);
                line_bytes[k+2] = hex_char(x[3:0], 1'b0);
                break;
            end
    endfunction

    function automatic void push_number();
        case ($urandom_range(0, 5))
            0: ;
            1: push_text($sformatf("%0d", $urandom_range(0, 9)));
            2: push_text($sformatf("%0d", $urandom_range(0, 255)));
            3: push_text($sformatf("%0d", $urandom_range(256, 99999)));
            4:
            begin
                if ($urandom_range(0, 1))
                    push_text(" ");
                push_text($urandom_range(0, 1) ? "-" : "+");
                push_text($sformatf("%02d", $urandom_range(0, 400)));
            end
            default: push_text("x7");
        endcase
    endfunction

    // Well-formed sentence with random content, mostly with a good checksum.
    function automatic void make_sentence();
        string      filler;
        logic [7:0] x;
        int         nf;
        int         form;
        filler = "0123456789.NSEWAMTK -+*$";
        line_bytes.delete();
        case ($urandom_range(0, 4))
            0, 1: push_text("$GPGGA");
            2: push_text("$GPVTG");
            3: push_text("$GPRMC");
            default:
            begin
                push_text("$");
                repeat ($urandom_range(0, 5))
                    line_bytes.push_back($urandom_range(8'h41, 8'h5A));
            end
        endcase
        nf = $urandom_range(0, 10);
        for (int f = 1; f <= nf; f++)
        begin
            line_bytes.push_back(CH_COMMA);
            if (f == FIELD_QUALITY || f == FIELD_SATS)
                push_number();
            else
                repeat ($urandom_range(0, 6))
                    if ($urandom_range(0, 19) == 0)
                        line_bytes.push_back(any_but_lf());
                    else
                        line_bytes.push_back(filler[$urandom_range(0, filler.len() - 1)]);
        end
        x = 8'd0;
        for (int i = 1; i < line_bytes.size(); i++)
            x ^= line_bytes[i];
        line_bytes.push_back(CH_STAR);
        form = $urandom_range(0, 99);
        if (form < 85)
        begin
            line_bytes.push_back(hex_char(x[7:4], form >= 75));
            line_bytes.push_back(hex_char(x[3:0], form >= 75));
        end
        else if (form < 90)
        begin
            x ^= $urandom_range(1, 255);
            line_bytes.push_back(hex_char(x[7:4], 1'b0));
            line_bytes.push_back(hex_char(x[3:0], 1'b0));
        end
        else if (form < 95)
        begin
            case ($urandom_range(0, 3))
                0: push_text(" ");
                1: push_text("\t");
                2: push_text("+");
                default: push_text("-");
            endcase
            line_bytes.push_back(hex_char(x[3:0], 1'b0));
        end
        else if (form < 97)
        begin
            line_bytes.push_back(hex_char(x[7:4], 1'b0));
            push_text("G");
        end
        else
        begin
            line_bytes.push_back(any_but_lf());
            line_bytes.push_back(any_but_lf());
        end
        repeat ($urandom_range(0, 2))
            line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    function automatic void damage_sentence();
        if ($urandom_range(0, 1))
            line_bytes[$urandom_range(0, line_bytes.size() - 2)] = any_but_lf();
        else
            repeat ($urandom_range(1, 4))
                if (line_bytes.size() > 1)
                    line_bytes.delete(line_bytes.size() - 2);
    endfunction

    function automatic void make_noise();
        line_bytes.delete();
        if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(240, 300))
                line_bytes.push_back(any_but_lf());
        else
            repeat ($urandom_range(0, 12))
                line_bytes.push_back($urandom_range(0, 255));
        line_bytes.push_back(CH_LF);
    endfunction

    // Offer one character; on acceptance record what the line produces.
    task automatic send_byte(logic [7:0] b, bit typed, report_t want);
        int      gap;
        report_t predicted;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (model_char(b, predicted))
            pending_reports.push_back(typed ? want : predicted);
    endtask

    function automatic void field_check(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Result side: check each accepted result and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got 0x%08h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                head = pending_reports.pop_front();
                field_check("line_status", head.status, m_axis_tdata[2:0]);
                field_check("sentence_kind", head.kind, m_axis_tdata[4:3]);
                field_check("computed_checksum", head.csum, m_axis_tdata[12:5]);
                field_check("fix_quality", head.quality, m_axis_tdata[20:13]);
                field_check("satellite_count", head.sats, m_axis_tdata[28:21]);
                field_check("pad bits", 0, m_axis_tdata[31:29]);
            end
        end
        if ($urandom_range(0, 299) == 0)
            rx_steady = !rx_steady;
        if (stall_left == 0)
            stall_left = pick_gap(rx_steady);
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int random_sent;
        bit held_off;
        int pick;

        random_sent = 0;
        held_off = 1'b0;

        // Typed rows come before any GGA sentence, so the held values are still zero.
        add_row("\n",                  1, 1, '{ST_SHORT, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("$*0\r\n",             1, 1, '{ST_SHORT, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("A$*00\n",             1, 1, '{ST_NODOLLAR, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("$ABCDE\n",            1, 1, '{ST_NOSTAR, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("~",                 255, 1, '{ST_OVERFLOW, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("~",                 254, 0, NO_REPORT);
        add_row("\n",                  1, 1, '{ST_NODOLLAR, KIND_OTHER, 8'd0, 8'd0, 8'd0});
        add_row("$GPGGA*ZZ\n",         1, 0, NO_REPORT);
        add_row("$GPGGA*00\r\r\n",     1, 0, NO_REPORT);
        add_row("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*hh\r\n",
                1, 0, NO_REPORT);
        add_row("$GPGGA,,,,,, -7,+300,*hh\n", 1, 0, NO_REPORT);
        add_row("$GPGGA,,,,,,,x*hh\n", 1, 0, NO_REPORT);
        add_row("$GPGGA,1,2*hh\n",     1, 0, NO_REPORT);
        add_row("$GPVTG,054.7,T,,M,005.5,N*hh\r\n", 1, 0, NO_REPORT);
        add_row("$GPRMC,123519,A*hh\n", 1, 0, NO_REPORT);
        add_row("$GPXYZ,1*hh\n",       1, 0, NO_REPORT);
        add_row("$A*hh\n",             1, 0, NO_REPORT);
        add_row("$AA* 0\n",            1, 0, NO_REPORT);
        add_row("$AB*+3\n",            1, 0, NO_REPORT);
        add_row("$AA*-0\n",            1, 0, NO_REPORT);
        add_row("$AB*-3\n",            1, 0, NO_REPORT);
        add_row("$AB*3G\n",            1, 0, NO_REPORT);
        add_row("$JA*0b\n",            1, 0, NO_REPORT);
        add_row("$`A*hh\n",            1, 0, NO_REPORT);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            build_row(rows[r].text, rows[r].rep);
            foreach (line_bytes[i])
                send_byte(line_bytes[i], rows[r].typed, rows[r].want);
        end

        while (random_sent < RANDOM_BYTES)
        begin
            // Hold off once until every outstanding request has drained.
            if (!held_off && random_sent >= RANDOM_BYTES / 2)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_reports.size() != 0);
                held_off = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                tx_steady = !tx_steady;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                make_sentence();
            else if (pick < 88)
            begin
                make_sentence();
                damage_sentence();
            end
            else
                make_noise();
            foreach (line_bytes[i])
                send_byte(line_bytes[i], 1'b0, NO_REPORT);
            random_sent += line_bytes.size();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
